FILE: src/midi_running_status_parser_top_macros.svh
// assertion macros for the midi running status parser
// used by midi_running_status_parser_top, expects clk and rst_n in scope
`ifndef MIDI_RUNNING_STATUS_PARSER_TOP_MACROS_SVH
`define MIDI_RUNNING_STATUS_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define MRSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mrsp_pkg.sv
// shared types, codes and helpers for the midi running status parser
// no dependencies
`timescale 1ns / 1ps

package mrsp_pkg;

    localparam int OPERATORS_DEF = 4;
    localparam int OP_SLOTS      = 4;

    localparam int CENTER_W = 14;
    localparam int RATIO_W  = 8;
    localparam int PITCH_W  = 8;
    localparam int BEND_W   = 11;
    localparam int ADDR_W   = 5;

    // result event codes
    localparam logic [1:0] EV_VOICE_ON  = 2'd0;
    localparam logic [1:0] EV_VOICE_OFF = 2'd1;
    localparam logic [1:0] EV_CLEAR_ALL = 2'd2;
    localparam logic [1:0] EV_BEND      = 2'd3;

    // status high nibbles
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY_PRESS = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG   = 4'hB;
    localparam logic [3:0] ST_PITCH_BEND = 4'hE;

    // register indexes
    localparam logic [2:0] REG_BEND_CENTER = 3'd0;
    localparam logic [2:0] REG_RATIO_OP0   = 3'd1;
    localparam logic [2:0] REG_RATIO_OP1   = 3'd2;
    localparam logic [2:0] REG_RATIO_OP2   = 3'd3;
    localparam logic [2:0] REG_RATIO_OP3   = 3'd4;

    localparam logic [CENTER_W-1:0] BEND_CENTER_RST = 14'd8192;
    localparam logic [RATIO_W-1:0]  RATIO_RST       = 8'd16;

    typedef logic [OP_SLOTS-1:0][RATIO_W-1:0] ratio_vec_t;

    typedef struct packed {
        logic [1:0]         ev;
        logic [6:0]         key;
        logic [PITCH_W-1:0] pitch;
    } job_t;

    function automatic logic [BEND_W-1:0] sat_bend(input logic [12:0] v);
        logic [BEND_W-1:0] r;
        if (v[12:10] == 3'b000 || v[12:10] == 3'b111)
        begin
            r = v[BEND_W-1:0];
        end
        else if (v[12])
        begin
            r = {1'b1, {(BEND_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(BEND_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: src/mrsp_parser.sv
// running status and pending data byte tracking, forms one job per completed message
// depends on mrsp_pkg
`timescale 1ns / 1ps

module mrsp_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_in,
    input  logic [mrsp_pkg::CENTER_W-1:0] bend_center,
    output logic                          job_load,
    output mrsp_pkg::job_t                job
);

    logic [7:0] rs_reg;
    logic [7:0] rs_next;
    logic       pv_reg;
    logic       pv_next;
    logic [6:0] pd_reg;
    logic [6:0] pd_next;

    logic [13:0] raw;
    logic [14:0] diff;

    assign raw  = {data_in[6:0], pd_reg};
    assign diff = {1'b0, raw} - {1'b0, bend_center};

    always_comb
    begin
        rs_next   = rs_reg;
        pv_next   = pv_reg;
        pd_next   = pd_reg;
        job_load  = 1'b0;
        job.ev    = mrsp_pkg::EV_CLEAR_ALL;
        job.key   = 7'd0;
        job.pitch = diff[14:7];
        if (accept)
        begin
            if (data_in[7])
            begin
                rs_next = data_in;
                pv_next = 1'b0;
            end
            else
            begin
                case (rs_reg[7:4])
                    mrsp_pkg::ST_NOTE_OFF,
                    mrsp_pkg::ST_NOTE_ON:
                    begin
                        if (!pv_reg)
                        begin
                            pv_next = 1'b1;
                            pd_next = data_in[6:0];
                        end
                        else
                        begin
                            pv_next  = 1'b0;
                            job_load = 1'b1;
                            job.key  = pd_reg;
                            if (rs_reg[7:4] == mrsp_pkg::ST_NOTE_ON && data_in != 8'd0)
                            begin
                                job.ev = mrsp_pkg::EV_VOICE_ON;
                            end
                            else
                            begin
                                job.ev = mrsp_pkg::EV_VOICE_OFF;
                            end
                        end
                    end
                    mrsp_pkg::ST_POLY_PRESS,
                    mrsp_pkg::ST_CTRL_CHG:
                    begin
                        if (!pv_reg)
                        begin
                            pv_next = 1'b1;
                            pd_next = data_in[6:0];
                        end
                        else
                        begin
                            pv_next  = 1'b0;
                            job_load = 1'b1;
                        end
                    end
                    mrsp_pkg::ST_PITCH_BEND:
                    begin
                        if (!pv_reg)
                        begin
                            pv_next = 1'b1;
                            pd_next = data_in[6:0];
                        end
                        else
                        begin
                            // low byte stays pending
                            job_load = 1'b1;
                            job.ev   = mrsp_pkg::EV_BEND;
                        end
                    end
                    default:
                    begin
                        pv_next  = 1'b0;
                        job_load = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= 8'd0;
            pv_reg <= 1'b0;
        end
        else
        begin
            rs_reg <= rs_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg <= pd_next;
    end

endmodule

FILE: src/mrsp_emit.sv
// job and output regs, one word per cycle unless stalled, bend scaling per operator
// depends on mrsp_pkg
`timescale 1ns / 1ps

module mrsp_emit
#(
    parameter int OPERATORS = mrsp_pkg::OPERATORS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_load,
    input  mrsp_pkg::job_t              job,
    input  mrsp_pkg::ratio_vec_t        ratio,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  ev,
    output logic [6:0]                  key,
    output logic [1:0]                  op_sel,
    output logic [mrsp_pkg::BEND_W-1:0] bend,
    output logic                        last
);

    localparam logic [1:0] OP_LAST = 2'(OPERATORS - 1);

    logic           jv_reg;
    logic           jv_next;
    mrsp_pkg::job_t job_reg;
    mrsp_pkg::job_t job_next;
    logic [1:0]     op_reg;
    logic [1:0]     op_next;

    logic                        ov_reg;
    logic                        ov_next;
    logic [1:0]                  ev_reg;
    logic [6:0]                  key_reg;
    logic [1:0]                  opi_reg;
    logic [mrsp_pkg::BEND_W-1:0] bend_reg;
    logic                        last_reg;

    logic                out_load;
    logic                job_fire;
    logic                job_last;
    logic                job_done;
    logic                is_bend;
    logic signed [8:0]   ratio_s;
    logic signed [16:0]  prod;

    assign is_bend  = (job_reg.ev == mrsp_pkg::EV_BEND);
    assign out_load = !ov_reg || out_ready;
    assign job_fire = jv_reg && out_load;
    assign job_last = !is_bend || (op_reg == OP_LAST);
    assign job_done = job_fire && job_last;
    assign ready    = !jv_reg || job_done;

    assign ratio_s = signed'({1'b0, ratio[op_reg]});
    assign prod    = ratio_s * signed'(job_reg.pitch);

    always_comb
    begin
        jv_next  = jv_reg;
        job_next = job_reg;
        op_next  = op_reg;
        if (job_load)
        begin
            jv_next  = 1'b1;
            job_next = job;
            op_next  = 2'd0;
        end
        else if (job_done)
        begin
            jv_next = 1'b0;
        end
        else if (job_fire)
        begin
            op_next = op_reg + 2'd1;
        end
        ov_next = out_load ? jv_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg <= 1'b0;
            ov_reg <= 1'b0;
            op_reg <= 2'd0;
        end
        else
        begin
            jv_reg <= jv_next;
            ov_reg <= ov_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (job_fire)
        begin
            ev_reg   <= job_reg.ev;
            key_reg  <= is_bend ? 7'd0 : job_reg.key;
            opi_reg  <= is_bend ? op_reg : 2'd0;
            bend_reg <= is_bend ? mrsp_pkg::sat_bend(prod[16:4]) : '0;
            last_reg <= job_last;
        end
    end

    assign out_valid = ov_reg;
    assign ev        = ev_reg;
    assign key       = key_reg;
    assign op_sel    = opi_reg;
    assign bend      = bend_reg;
    assign last      = last_reg;

endmodule

FILE: src/midi_running_status_parser_top.sv
// midi running status parser top level: config registers, parser and result emitter
// depends on mrsp_pkg, mrsp_parser, mrsp_emit, midi_running_status_parser_top_macros.svh
//
//  channel   dir  signals                         contents
//  s_axis    in   tvalid tready tdata[7:0]        midi_byte
//  m_axis    out  tvalid tready tdata[23:0] tlast event_res, key, operator_index, bend_amount
//  apb       in   psel penable pwrite paddr[4:0]  bend_center at 0x00, ratio_op0..3 at 0x04..0x10
//
// a byte that completes nothing never loads the job register; one that gives a single result
// loads it for one result word. a completed pitch bend holds the job register while it steps
// through all OPERATORS operators one at a time on the shared 9x8 multiplier.
// the output register lets the next byte in while a result word waits to be taken.
// reset clears running status and the pending-byte flag and loads register defaults.
`timescale 1ns / 1ps

`include "midi_running_status_parser_top_macros.svh"

module midi_running_status_parser_top
#(
    parameter int OPERATORS = mrsp_pkg::OPERATORS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] midi_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [1:0] event_res, [8:2] key, [10:9] operator_index, [21:11] bend_amount, [23:22] zero
    output logic [23:0]                 m_axis_tdata,
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [1:0] OP_LAST = 2'(OPERATORS - 1);

    logic [mrsp_pkg::CENTER_W-1:0] center_reg;
    logic [mrsp_pkg::CENTER_W-1:0] center_next;
    mrsp_pkg::ratio_vec_t          ratio_reg;
    mrsp_pkg::ratio_vec_t          ratio_next;

    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic           accept;
    logic           job_load;
    mrsp_pkg::job_t job;

    logic [1:0]                  ev;
    logic [6:0]                  key;
    logic [1:0]                  op_sel;
    logic [mrsp_pkg::BEND_W-1:0] bend;

    logic                          out_bend;
    logic                          out_plain;
    logic                          plain_ok;
    logic                          center_wr;
    logic [mrsp_pkg::CENTER_W-1:0] center_wdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        center_next = center_reg;
        ratio_next  = ratio_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                mrsp_pkg::REG_BEND_CENTER: center_next  = pwdata[mrsp_pkg::CENTER_W-1:0];
                mrsp_pkg::REG_RATIO_OP0:   ratio_next[0] = pwdata[mrsp_pkg::RATIO_W-1:0];
                mrsp_pkg::REG_RATIO_OP1:   ratio_next[1] = pwdata[mrsp_pkg::RATIO_W-1:0];
                mrsp_pkg::REG_RATIO_OP2:   ratio_next[2] = pwdata[mrsp_pkg::RATIO_W-1:0];
                mrsp_pkg::REG_RATIO_OP3:   ratio_next[3] = pwdata[mrsp_pkg::RATIO_W-1:0];
                default:                   center_next  = center_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mrsp_pkg::REG_BEND_CENTER: prdata = {18'd0, center_reg};
            mrsp_pkg::REG_RATIO_OP0:   prdata = {24'd0, ratio_reg[0]};
            mrsp_pkg::REG_RATIO_OP1:   prdata = {24'd0, ratio_reg[1]};
            mrsp_pkg::REG_RATIO_OP2:   prdata = {24'd0, ratio_reg[2]};
            mrsp_pkg::REG_RATIO_OP3:   prdata = {24'd0, ratio_reg[3]};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= mrsp_pkg::BEND_CENTER_RST;
            ratio_reg  <= {mrsp_pkg::OP_SLOTS{mrsp_pkg::RATIO_RST}};
        end
        else
        begin
            center_reg <= center_next;
            ratio_reg  <= ratio_next;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    mrsp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_in     (s_axis_tdata),
        .bend_center (center_reg),
        .job_load    (job_load),
        .job         (job)
    );

    mrsp_emit #(
        .OPERATORS (OPERATORS)
    ) u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .ratio     (ratio_reg),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ev        (ev),
        .key       (key),
        .op_sel    (op_sel),
        .bend      (bend),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, bend, op_sel, key, ev};

    assign out_bend     = m_axis_tvalid && ev == mrsp_pkg::EV_BEND;
    assign out_plain    = m_axis_tvalid && ev != mrsp_pkg::EV_BEND;
    assign plain_ok     = m_axis_tlast && op_sel == 2'd0 && bend == '0;
    assign center_wr    = cfg_wr && reg_idx == mrsp_pkg::REG_BEND_CENTER;
    assign center_wdata = pwdata[mrsp_pkg::CENTER_W-1:0];

    `MRSP_ASSERT_NOW(a_bend_last, out_bend, m_axis_tlast == (op_sel == OP_LAST), "bend tlast misplaced")
    `MRSP_ASSERT_NOW(a_plain_single, out_plain, plain_ok, "non-bend word malformed")
    `MRSP_ASSERT_NOW(a_bend_nokey, out_bend, key == 7'd0, "bend word carries a key")
    `MRSP_ASSERT_NEXT(a_center_wr, center_wr, center_reg == $past(center_wdata), "center write lost")

endmodule
